/* design/gbe_pkg.sv */
package gbe_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int BIAS_FRAC_BITS  = 16;
    localparam int COUNT_WIDTH     = 20;
    localparam int AXES            = 3;

    localparam int TIME_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int THR_WIDTH       = 15;
    localparam int ALPHA_WIDTH     = 17;
    localparam int ALPHA_FRAC      = 16;
    localparam int OUT_WIDTH       = SAMPLE_WIDTH + 1;

    // startup sum and bias
    localparam int SUM_WIDTH       = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int MAG_WIDTH       = SUM_WIDTH - 1;
    localparam int BIAS_WIDTH      = SAMPLE_WIDTH + BIAS_FRAC_BITS + 1;
    localparam int DIFF_WIDTH      = BIAS_WIDTH + 1;
    localparam int QUOT_WIDTH      = SAMPLE_WIDTH + BIAS_FRAC_BITS;
    localparam int NUM_WIDTH       = MAG_WIDTH + BIAS_FRAC_BITS + 1;
    localparam int DIV_CNT_WIDTH   = $clog2(QUOT_WIDTH);
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(QUOT_WIDTH - 1);
    localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // EMA product split at ALPHA_FRAC
    localparam int DH_WIDTH        = DIFF_WIDTH - ALPHA_FRAC;
    localparam int PHI_WIDTH       = DH_WIDTH + ALPHA_WIDTH + 1;
    localparam int PLO_WIDTH       = ALPHA_WIDTH + ALPHA_FRAC;
    localparam int PROD_WIDTH      = DIFF_WIDTH + ALPHA_WIDTH + 1;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1 << ALPHA_FRAC);

    // stationary test
    localparam int SQ_WIDTH        = 2 * SAMPLE_WIDTH - 1;
    localparam int SQSUM_WIDTH     = 2 * SAMPLE_WIDTH;
    localparam int HI_WIDTH        = THR_WIDTH + 1;
    localparam int HI2_WIDTH       = 2 * HI_WIDTH;
    localparam int CMP_WIDTH       = (SQSUM_WIDTH > HI2_WIDTH) ? SQSUM_WIDTH : HI2_WIDTH;

    localparam logic [TIME_WIDTH-1:0]  CALIB_MS_RST  = TIME_WIDTH'(8000);
    localparam logic [THR_WIDTH-1:0]   GYRO_THR_RST  = THR_WIDTH'(80);
    localparam logic [THR_WIDTH-1:0]   ACCEL_TOL_RST = THR_WIDTH'(750);
    localparam logic [THR_WIDTH-1:0]   GRAVITY_RST   = THR_WIDTH'(9807);
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_RST     = ALPHA_WIDTH'(66);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CALIB_MS  = 3'd0,
        REG_GYRO_THR  = 3'd1,
        REG_ACCEL_TOL = 3'd2,
        REG_GRAVITY   = 3'd3,
        REG_ALPHA     = 3'd4
    } gbe_reg_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]  calib_ms;
        logic [THR_WIDTH-1:0]   gyro_thr;
        logic [THR_WIDTH-1:0]   accel_tol;
        logic [THR_WIDTH-1:0]   gravity;
        logic [ALPHA_WIDTH-1:0] alpha;
    } gbe_cfg_t;

    typedef struct packed {
        logic                   latch;
        logic                   prep;
        logic                   acc;
        logic                   load;
        logic                   div;
        logic                   fin;
        logic                   out;
        logic                   mul;
        logic                   commit;
        logic [COUNT_WIDTH-1:0] count;
        logic [ALPHA_WIDTH-1:0] alpha;
    } gbe_ctrl_t;

    typedef struct packed {
        logic [SQ_WIDTH-1:0] g2;
        logic [SQ_WIDTH-1:0] a2;
    } gbe_sq_t;

endpackage

/* design/gbe_lane.sv */
module gbe_lane (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  gbe_pkg::gbe_ctrl_t                         ctrl,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    gyro,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    accel,
    output logic signed [gbe_pkg::OUT_WIDTH-1:0]       corr,
    output gbe_pkg::gbe_sq_t                           sq
);

    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] g_reg;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] a_reg;
    logic signed [gbe_pkg::SUM_WIDTH-1:0]    sum_reg;
    logic signed [gbe_pkg::BIAS_WIDTH-1:0]   bias_reg;
    logic signed [gbe_pkg::BIAS_WIDTH-1:0]   bias_next;
    logic [gbe_pkg::SQ_WIDTH-1:0]            g2_reg;
    logic [gbe_pkg::SQ_WIDTH-1:0]            a2_reg;

    logic [gbe_pkg::COUNT_WIDTH-1:0]         rem_reg;
    logic [gbe_pkg::COUNT_WIDTH-1:0]         rem_next;
    logic [gbe_pkg::QUOT_WIDTH-1:0]          quo_reg;
    logic                                    neg_reg;

    logic signed [gbe_pkg::DIFF_WIDTH-1:0]   diff_reg;
    logic signed [gbe_pkg::DIFF_WIDTH-1:0]   diff_next;
    logic signed [gbe_pkg::PHI_WIDTH-1:0]    phi_reg;
    logic [gbe_pkg::PLO_WIDTH-1:0]           plo_reg;

    logic signed [2*gbe_pkg::SAMPLE_WIDTH-1:0] g_sq;
    logic signed [2*gbe_pkg::SAMPLE_WIDTH-1:0] a_sq;
    logic [gbe_pkg::MAG_WIDTH-1:0]           sum_mag;
    logic [gbe_pkg::NUM_WIDTH-1:0]           num;
    logic [gbe_pkg::COUNT_WIDTH:0]           trial;
    logic                                    trial_ge;
    logic signed [gbe_pkg::DIFF_WIDTH-1:0]   rounded;
    logic signed [gbe_pkg::PROD_WIDTH-1:0]   ema_prod;

    assign g_sq = g_reg * g_reg;
    assign a_sq = a_reg * a_reg;
    assign sq.g2 = g2_reg;
    assign sq.a2 = a2_reg;

    assign diff_next = $signed({g_reg, {gbe_pkg::BIAS_FRAC_BITS{1'b0}}})
                     - gbe_pkg::DIFF_WIDTH'(bias_reg);
    assign rounded   = diff_next
                     + $signed(gbe_pkg::DIFF_WIDTH'(1 << (gbe_pkg::BIAS_FRAC_BITS - 1)));
    assign corr      = rounded[gbe_pkg::BIAS_FRAC_BITS +: gbe_pkg::OUT_WIDTH];

    // magnitude of the sum in Q.FRAC, biased by count/2 for round half away from zero
    assign sum_mag = sum_reg[gbe_pkg::SUM_WIDTH-1]
                   ? gbe_pkg::MAG_WIDTH'(-sum_reg)
                   : gbe_pkg::MAG_WIDTH'(sum_reg);
    assign num = gbe_pkg::NUM_WIDTH'({sum_mag, {gbe_pkg::BIAS_FRAC_BITS{1'b0}}})
               + gbe_pkg::NUM_WIDTH'(ctrl.count >> 1);

    assign trial    = {rem_reg, quo_reg[gbe_pkg::QUOT_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, ctrl.count};
    assign rem_next = trial_ge
                    ? gbe_pkg::COUNT_WIDTH'(trial - {1'b0, ctrl.count})
                    : trial[gbe_pkg::COUNT_WIDTH-1:0];

    assign ema_prod = $signed({phi_reg, {gbe_pkg::ALPHA_FRAC{1'b0}}})
                    + $signed(gbe_pkg::PROD_WIDTH'(plo_reg))
                    + $signed(gbe_pkg::PROD_WIDTH'(1 << (gbe_pkg::ALPHA_FRAC - 1)));

    always_comb
    begin
        bias_next = bias_reg;
        if (ctrl.fin)
        begin
            bias_next = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        end
        else if (ctrl.commit)
        begin
            bias_next = bias_reg + ema_prod[gbe_pkg::ALPHA_FRAC +: gbe_pkg::BIAS_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end
        else
        begin
            if (ctrl.acc)
            begin
                sum_reg <= sum_reg + gbe_pkg::SUM_WIDTH'(g_reg);
            end
            bias_reg <= bias_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            g_reg <= gyro;
            a_reg <= accel;
        end
        if (ctrl.prep)
        begin
            g2_reg <= g_sq[gbe_pkg::SQ_WIDTH-1:0];
            a2_reg <= a_sq[gbe_pkg::SQ_WIDTH-1:0];
        end
        if (ctrl.load)
        begin
            rem_reg <= num[gbe_pkg::NUM_WIDTH-1:gbe_pkg::QUOT_WIDTH];
            quo_reg <= num[gbe_pkg::QUOT_WIDTH-1:0];
            neg_reg <= sum_reg[gbe_pkg::SUM_WIDTH-1];
        end
        else if (ctrl.div)
        begin
            // one quotient bit per cycle, shifted in behind the dividend
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[gbe_pkg::QUOT_WIDTH-2:0], trial_ge};
        end
        if (ctrl.out)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.mul)
        begin
            phi_reg <= $signed({1'b0, ctrl.alpha})
                     * $signed(diff_reg[gbe_pkg::DIFF_WIDTH-1:gbe_pkg::ALPHA_FRAC]);
            plo_reg <= ctrl.alpha * diff_reg[gbe_pkg::ALPHA_FRAC-1:0];
        end
    end

endmodule

/* design/gbe_merge.sv */
module gbe_merge (
    input  logic                clk,
    input  gbe_pkg::gbe_ctrl_t  ctrl,
    input  gbe_pkg::gbe_cfg_t   cfg,
    input  gbe_pkg::gbe_sq_t    sq [gbe_pkg::AXES],
    input  logic                calibrated,
    output logic                stationary
);

    logic [gbe_pkg::HI2_WIDTH-1:0]   thr2_reg;
    logic [gbe_pkg::HI2_WIDTH-1:0]   hi2_reg;
    logic [gbe_pkg::HI2_WIDTH-1:0]   lo2_reg;
    logic                            lo_chk_reg;

    logic [gbe_pkg::HI_WIDTH-1:0]    thr_ext;
    logic [gbe_pkg::HI_WIDTH-1:0]    hi;
    logic [gbe_pkg::HI_WIDTH-1:0]    lo;
    logic [gbe_pkg::SQSUM_WIDTH-1:0] g2_sum;
    logic [gbe_pkg::SQSUM_WIDTH-1:0] a2_sum;
    logic [gbe_pkg::CMP_WIDTH-1:0]   g2_cmp;
    logic [gbe_pkg::CMP_WIDTH-1:0]   a2_cmp;

    assign thr_ext = gbe_pkg::HI_WIDTH'(cfg.gyro_thr);
    assign hi      = gbe_pkg::HI_WIDTH'(cfg.gravity) + gbe_pkg::HI_WIDTH'(cfg.accel_tol);
    assign lo      = gbe_pkg::HI_WIDTH'(cfg.gravity) - gbe_pkg::HI_WIDTH'(cfg.accel_tol);

    // bounds are squared once per sample; config holds still while busy is a rule for the user, not enforced here
    always_ff @(posedge clk)
    begin
        if (ctrl.prep)
        begin
            thr2_reg   <= thr_ext * thr_ext;
            hi2_reg    <= hi * hi;
            lo2_reg    <= lo * lo;
            lo_chk_reg <= cfg.gravity >= cfg.accel_tol;
        end
    end

    always_comb
    begin
        g2_sum = '0;
        a2_sum = '0;
        for (int i = 0; i < gbe_pkg::AXES; i++)
        begin
            g2_sum = g2_sum + gbe_pkg::SQSUM_WIDTH'(sq[i].g2);
            a2_sum = a2_sum + gbe_pkg::SQSUM_WIDTH'(sq[i].a2);
        end
    end

    assign g2_cmp = gbe_pkg::CMP_WIDTH'(g2_sum);
    assign a2_cmp = gbe_pkg::CMP_WIDTH'(a2_sum);

    assign stationary = calibrated
                     && (g2_cmp < gbe_pkg::CMP_WIDTH'(thr2_reg))
                     && (a2_cmp < gbe_pkg::CMP_WIDTH'(hi2_reg))
                     && (!lo_chk_reg || (a2_cmp > gbe_pkg::CMP_WIDTH'(lo2_reg)));

endmodule

/* design/gyro_bias_estimator.sv */
// Channel   Direction  Signals
// -------   ---------  ------------------------------------------------------------
// in        request    in_valid/in_ready, time_ms, gyro_x..z, accel_x..z
// out       request    out_valid/out_ready, rate_x..z_corrected, is_calibrated,
//                      was_stationary
// cfg       request    cfg_valid/cfg_ready (always high), cfg_index, cfg_data
//
// A sample passes through the accept, accumulate and output steps, plus a multiply
// step when the zero-rate update runs (two split multiplies per axis lane, committed in the cycle after).
// The sample that ends calibration also passes through load, divide and finish steps: the
// per-axis restoring divider produces one of 32 quotient bits per cycle.
// The next request is taken once the result sits in the output register and any zero-rate
// multiply is done; a stalled output holds the block in its output step.
// Reset clears control state, sums, bias and restores register defaults.
module gyro_bias_estimator (
    input  logic                                         clk,
    input  logic                                         rst_n,

    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [gbe_pkg::TIME_WIDTH-1:0]               time_ms,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      gyro_x,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      gyro_y,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      gyro_z,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      accel_x,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      accel_y,
    input  logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]      accel_z,

    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic signed [gbe_pkg::OUT_WIDTH-1:0]         rate_x_corrected,
    output logic signed [gbe_pkg::OUT_WIDTH-1:0]         rate_y_corrected,
    output logic signed [gbe_pkg::OUT_WIDTH-1:0]         rate_z_corrected,
    output logic                                         is_calibrated,
    output logic                                         was_stationary,

    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [gbe_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index,
    input  logic [gbe_pkg::CFG_DATA_WIDTH-1:0]           cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_MUL  = 7'b1000000
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;
    gbe_pkg::gbe_cfg_t                       cfg_reg;
    gbe_pkg::gbe_ctrl_t                      ctrl;
    logic [gbe_pkg::TIME_WIDTH-1:0]          time_reg;
    logic [gbe_pkg::COUNT_WIDTH-1:0]         count_reg;
    logic [gbe_pkg::DIV_CNT_WIDTH-1:0]       div_cnt_reg;
    logic                                    cal_reg;
    logic                                    commit_reg;
    logic                                    out_valid_reg;
    logic signed [gbe_pkg::OUT_WIDTH-1:0]    rate_reg [gbe_pkg::AXES];
    logic                                    out_cal_reg;
    logic                                    out_stat_reg;

    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] gyro_in  [gbe_pkg::AXES];
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] accel_in [gbe_pkg::AXES];
    logic signed [gbe_pkg::OUT_WIDTH-1:0]    corr     [gbe_pkg::AXES];
    gbe_pkg::gbe_sq_t                        sq       [gbe_pkg::AXES];
    logic                                    stationary;
    logic                                    out_free;
    logic                                    finalize;
    logic                                    adapt;
    logic [gbe_pkg::ALPHA_WIDTH-1:0]         alpha_eff;

    assign gyro_in[0]  = gyro_x;
    assign gyro_in[1]  = gyro_y;
    assign gyro_in[2]  = gyro_z;
    assign accel_in[0] = accel_x;
    assign accel_in[1] = accel_y;
    assign accel_in[2] = accel_z;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign finalize  = !cal_reg && (time_reg >= cfg_reg.calib_ms);
    assign adapt     = stationary && (cfg_reg.alpha != '0);
    assign alpha_eff = (cfg_reg.alpha > gbe_pkg::ALPHA_ONE) ? gbe_pkg::ALPHA_ONE : cfg_reg.alpha;

    always_comb
    begin
        ctrl.latch  = (state_reg == S_IDLE) && in_valid;
        ctrl.prep   = state_reg == S_ACC;
        ctrl.acc    = (state_reg == S_ACC) && !cal_reg && (count_reg != gbe_pkg::COUNT_MAX);
        ctrl.load   = state_reg == S_LOAD;
        ctrl.div    = state_reg == S_DIV;
        ctrl.fin    = state_reg == S_FIN;
        ctrl.out    = (state_reg == S_OUT) && out_free;
        ctrl.mul    = state_reg == S_MUL;
        ctrl.commit = commit_reg;
        ctrl.count  = count_reg;
        ctrl.alpha  = alpha_eff;
    end

    for (genvar i = 0; i < gbe_pkg::AXES; i++)
    begin : g_lane
        gbe_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .gyro  (gyro_in[i]),
            .accel (accel_in[i]),
            .corr  (corr[i]),
            .sq    (sq[i])
        );
    end

    gbe_merge u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .sq         (sq),
        .calibrated (cal_reg),
        .stationary (stationary)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:  state_next = finalize ? S_LOAD : S_OUT;
            S_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == gbe_pkg::DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = adapt ? S_MUL : S_IDLE;
                end
            end
            S_MUL:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            div_cnt_reg   <= '0;
            cal_reg       <= 1'b0;
            commit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            commit_reg <= ctrl.mul;
            if (ctrl.acc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctrl.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctrl.div)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (ctrl.fin)
            begin
                cal_reg <= 1'b1;
            end
            if (ctrl.out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calib_ms  <= gbe_pkg::CALIB_MS_RST;
            cfg_reg.gyro_thr  <= gbe_pkg::GYRO_THR_RST;
            cfg_reg.accel_tol <= gbe_pkg::ACCEL_TOL_RST;
            cfg_reg.gravity   <= gbe_pkg::GRAVITY_RST;
            cfg_reg.alpha     <= gbe_pkg::ALPHA_RST;
        end
        else if (cfg_valid)
        begin
            unique case (gbe_pkg::gbe_reg_t'(cfg_index))
                gbe_pkg::REG_CALIB_MS:
                    cfg_reg.calib_ms  <= cfg_data[gbe_pkg::TIME_WIDTH-1:0];
                gbe_pkg::REG_GYRO_THR:
                    cfg_reg.gyro_thr  <= cfg_data[gbe_pkg::THR_WIDTH-1:0];
                gbe_pkg::REG_ACCEL_TOL:
                    cfg_reg.accel_tol <= cfg_data[gbe_pkg::THR_WIDTH-1:0];
                gbe_pkg::REG_GRAVITY:
                    cfg_reg.gravity   <= cfg_data[gbe_pkg::THR_WIDTH-1:0];
                gbe_pkg::REG_ALPHA:
                    cfg_reg.alpha     <= cfg_data[gbe_pkg::ALPHA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            time_reg <= time_ms;
        end
        if (ctrl.out)
        begin
            for (int i = 0; i < gbe_pkg::AXES; i++)
            begin
                rate_reg[i] <= corr[i];
            end
            out_cal_reg  <= cal_reg;
            out_stat_reg <= stationary;
        end
    end

    assign out_valid        = out_valid_reg;
    assign rate_x_corrected = rate_reg[0];
    assign rate_y_corrected = rate_reg[1];
    assign rate_z_corrected = rate_reg[2];
    assign is_calibrated    = out_cal_reg;
    assign was_stationary   = out_stat_reg;

endmodule

/* design/gbe_checker.sv */
module gbe_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [gbe_pkg::OUT_WIDTH-1:0]    rate_x_corrected,
    input  logic                                    is_calibrated,
    input  logic                                    was_stationary
);

    // one sample in flight: in_ready drops once a request is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken right after a previous one");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 !in_ready)
        else $error("sample finished in under three cycles");

    a_stat_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!was_stationary || is_calibrated))
        else $error("stationary flagged before calibration");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(rate_x_corrected)))
        else $error("stalled result dropped or changed");

endmodule

bind gyro_bias_estimator gbe_checker u_gbe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .rate_x_corrected (rate_x_corrected),
    .is_calibrated    (is_calibrated),
    .was_stationary   (was_stationary)
);

/* tb/tb_gyro_bias_estimator.sv */
module tb_gyro_bias_estimator;

    localparam int RAND_PHASES   = 10;
    localparam int PHASE_SAMPLES = 125;
    localparam int STALL_LIMIT   = 1000;
    localparam int IDLE_PCT      = 31;
    localparam int CALM_PHASE    = 5;
    localparam int AXIS_MAX      = (1 <<< (gbe_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam int AXIS_MIN      = -(1 <<< (gbe_pkg::SAMPLE_WIDTH - 1));
    localparam int LEVEL_MAX     = (1 <<< gbe_pkg::THR_WIDTH) - 1;
    localparam int ALPHA_MAX     = (1 <<< gbe_pkg::ALPHA_WIDTH) - 1;

    typedef struct {
        logic [gbe_pkg::TIME_WIDTH-1:0]          stamp;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] gx;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] gy;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] gz;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] ax;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] ay;
        logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] az;
    } imu_sample_t;

    typedef struct {
        logic signed [gbe_pkg::OUT_WIDTH-1:0] rate_x;
        logic signed [gbe_pkg::OUT_WIDTH-1:0] rate_y;
        logic signed [gbe_pkg::OUT_WIDTH-1:0] rate_z;
        logic                                 calibrated;
        logic                                 stationary;
    } corrected_rate_t;

    logic                                       clk = 1'b0;
    logic                                       rst_n;
    logic                                       in_valid;
    logic                                       in_ready;
    logic [gbe_pkg::TIME_WIDTH-1:0]             time_ms;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    gyro_x;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    gyro_y;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    gyro_z;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    accel_x;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    accel_y;
    logic signed [gbe_pkg::SAMPLE_WIDTH-1:0]    accel_z;
    logic                                       out_valid;
    logic                                       out_ready;
    logic signed [gbe_pkg::OUT_WIDTH-1:0]       rate_x_corrected;
    logic signed [gbe_pkg::OUT_WIDTH-1:0]       rate_y_corrected;
    logic signed [gbe_pkg::OUT_WIDTH-1:0]       rate_z_corrected;
    logic                                       is_calibrated;
    logic                                       was_stationary;
    logic                                       cfg_valid;
    logic                                       cfg_ready;
    logic [gbe_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index;
    logic [gbe_pkg::CFG_DATA_WIDTH-1:0]         cfg_data;

    // register copies
    logic [gbe_pkg::TIME_WIDTH-1:0]             calib_ms_r  = gbe_pkg::CALIB_MS_RST;
    logic [gbe_pkg::THR_WIDTH-1:0]              gyro_thr_r  = gbe_pkg::GYRO_THR_RST;
    logic [gbe_pkg::THR_WIDTH-1:0]              accel_tol_r = gbe_pkg::ACCEL_TOL_RST;
    logic [gbe_pkg::THR_WIDTH-1:0]              gravity_r   = gbe_pkg::GRAVITY_RST;
    logic [gbe_pkg::ALPHA_WIDTH-1:0]            alpha_r     = gbe_pkg::ALPHA_RST;

    // estimator state
    logic                                       calibrated    = 1'b0;
    logic [gbe_pkg::COUNT_WIDTH-1:0]            startup_count = '0;
    logic signed [gbe_pkg::SUM_WIDTH-1:0]       rate_sum [gbe_pkg::AXES];
    logic signed [gbe_pkg::BIAS_WIDTH-1:0]      rate_bias [gbe_pkg::AXES];

    imu_sample_t                       imu_queue [$];
    corrected_rate_t                   pending_rates [$];
    imu_sample_t                       next_sample;
    imu_sample_t                       seen_sample;
    corrected_rate_t                   want;
    corrected_rate_t                   got;
    logic                              in_taken = 1'b0;
    int                                idle_pct = IDLE_PCT;
    int                                mismatches = 0;
    int                                quiet_cycles = 0;

    gyro_bias_estimator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .time_ms          (time_ms),
        .gyro_x           (gyro_x),
        .gyro_y           (gyro_y),
        .gyro_z           (gyro_z),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .rate_x_corrected (rate_x_corrected),
        .rate_y_corrected (rate_y_corrected),
        .rate_z_corrected (rate_z_corrected),
        .is_calibrated    (is_calibrated),
        .was_stationary   (was_stationary),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic predict_rates(input imu_sample_t s, output corrected_rate_t r);
        longint g [gbe_pkg::AXES];
        longint a [gbe_pkg::AXES];
        longint fixed_rate [gbe_pkg::AXES];
        longint num, mag, quot, g2, a2, hi, lo, alpha, diff, incr;
        logic   still;
        int     i;
        g[0] = s.gx;
        g[1] = s.gy;
        g[2] = s.gz;
        a[0] = s.ax;
        a[1] = s.ay;
        a[2] = s.az;
        if (!calibrated)
        begin
            // saturated count: stop summing
            if (startup_count < gbe_pkg::COUNT_MAX)
            begin
                for (i = 0; i < gbe_pkg::AXES; i++)
                    rate_sum[i] = gbe_pkg::SUM_WIDTH'(rate_sum[i] + g[i]);
                startup_count = startup_count + 1'b1;
            end
            if (s.stamp >= calib_ms_r)
            begin
                if (startup_count != 0)
                begin
                    for (i = 0; i < gbe_pkg::AXES; i++)
                    begin
                        num = longint'(rate_sum[i]) <<< gbe_pkg::BIAS_FRAC_BITS;
                        mag = (num < 0) ? -num : num;
                        quot = (mag + longint'(startup_count) / 2) / longint'(startup_count);
                        rate_bias[i] = gbe_pkg::BIAS_WIDTH'((num < 0) ? -quot : quot);
                    end
                end
                calibrated = 1'b1;
            end
        end
        for (i = 0; i < gbe_pkg::AXES; i++)
            fixed_rate[i] = ((g[i] <<< gbe_pkg::BIAS_FRAC_BITS) - longint'(rate_bias[i])
                             + (longint'(1) <<< (gbe_pkg::BIAS_FRAC_BITS - 1)))
                            >>> gbe_pkg::BIAS_FRAC_BITS;
        still = 1'b0;
        if (calibrated)
        begin
            g2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
            a2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            hi = longint'(gravity_r) + longint'(accel_tol_r);
            still = (g2 < longint'(gyro_thr_r) * longint'(gyro_thr_r)) && (a2 < hi * hi);
            // lower accel bound only applies when gravity is not below the tolerance
            if (still && gravity_r >= accel_tol_r)
            begin
                lo = longint'(gravity_r) - longint'(accel_tol_r);
                still = a2 > lo * lo;
            end
        end
        if (still && alpha_r != 0)
        begin
            alpha = (alpha_r > gbe_pkg::ALPHA_ONE) ? longint'(gbe_pkg::ALPHA_ONE)
                                                   : longint'(alpha_r);
            for (i = 0; i < gbe_pkg::AXES; i++)
            begin
                diff = (g[i] <<< gbe_pkg::BIAS_FRAC_BITS) - longint'(rate_bias[i]);
                incr = (alpha * diff + (longint'(1) <<< (gbe_pkg::ALPHA_FRAC - 1)))
                       >>> gbe_pkg::ALPHA_FRAC;
                rate_bias[i] = gbe_pkg::BIAS_WIDTH'(longint'(rate_bias[i]) + incr);
            end
        end
        r.rate_x     = gbe_pkg::OUT_WIDTH'(fixed_rate[0]);
        r.rate_y     = gbe_pkg::OUT_WIDTH'(fixed_rate[1]);
        r.rate_z     = gbe_pkg::OUT_WIDTH'(fixed_rate[2]);
        r.calibrated = calibrated;
        r.stationary = still;
    endtask

    task automatic check_field(input string label, input longint exp_val, input longint act_val);
        if (exp_val != act_val)
        begin
            $display("%0t %s expected %0d actual %0d", $time, label, exp_val, act_val);
            mismatches++;
        end
    endtask

    function automatic logic signed [gbe_pkg::SAMPLE_WIDTH-1:0] clip_axis(input int v);
        if (v > AXIS_MAX)
            return gbe_pkg::SAMPLE_WIDTH'(AXIS_MAX);
        if (v < AXIS_MIN)
            return gbe_pkg::SAMPLE_WIDTH'(AXIS_MIN);
        return gbe_pkg::SAMPLE_WIDTH'(v);
    endfunction

    function automatic int pick_level(input int lo, input int hi, input int mid_lo, input int mid_hi);
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return lo;
        if (roll == 1)
            return hi;
        if (roll < 7)
            return $urandom_range(mid_hi, mid_lo);
        return $urandom_range(hi, lo);
    endfunction

    // mostly near-stationary samples around the current thresholds, some on the edges, some noise
    function automatic imu_sample_t make_sample();
        imu_sample_t s;
        int roll, span, axis, mag, lo_mag, hi_mag, thr, grav, tol, i;
        int gv [gbe_pkg::AXES];
        int av [gbe_pkg::AXES];
        roll = $urandom_range(99);
        thr = int'(gyro_thr_r);
        grav = int'(gravity_r);
        tol = int'(accel_tol_r);
        span = thr / 2;
        lo_mag = (grav > tol) ? grav - tol : 0;
        hi_mag = (grav + tol > AXIS_MAX) ? AXIS_MAX : grav + tol;
        mag = $urandom_range(hi_mag, lo_mag);
        for (i = 0; i < gbe_pkg::AXES; i++)
        begin
            gv[i] = int'($urandom_range(2 * span)) - span;
            av[i] = int'($urandom_range(16)) - 8;
        end
        if (roll >= 80 && roll < 90)
        begin
            axis = $urandom_range(2);
            gv[axis] = thr + int'($urandom_range(4)) - 2;
            if ($urandom_range(1))
                gv[axis] = -gv[axis];
        end
        else if (roll >= 90)
        begin
            mag = ($urandom_range(1) ? hi_mag : lo_mag) + int'($urandom_range(4)) - 2;
            av = '{0, 0, 0};
        end
        axis = $urandom_range(2);
        av[axis] = $urandom_range(1) ? mag : -mag;
        s.stamp = $urandom();
        if (roll < 20)
        begin
            s.gx = gbe_pkg::SAMPLE_WIDTH'($urandom());
            s.gy = gbe_pkg::SAMPLE_WIDTH'($urandom());
            s.gz = gbe_pkg::SAMPLE_WIDTH'($urandom());
            s.ax = gbe_pkg::SAMPLE_WIDTH'($urandom());
            s.ay = gbe_pkg::SAMPLE_WIDTH'($urandom());
            s.az = gbe_pkg::SAMPLE_WIDTH'($urandom());
        end
        else
        begin
            s.gx = clip_axis(gv[0]);
            s.gy = clip_axis(gv[1]);
            s.gz = clip_axis(gv[2]);
            s.ax = clip_axis(av[0]);
            s.ay = clip_axis(av[1]);
            s.az = clip_axis(av[2]);
        end
        return s;
    endfunction

    task automatic push_sample(input logic [gbe_pkg::TIME_WIDTH-1:0] stamp,
                               input int gx, input int gy, input int gz,
                               input int ax, input int ay, input int az);
        imu_sample_t s;
        s.stamp = stamp;
        s.gx = clip_axis(gx);
        s.gy = clip_axis(gy);
        s.gz = clip_axis(gz);
        s.ax = clip_axis(ax);
        s.ay = clip_axis(ay);
        s.az = clip_axis(az);
        imu_queue.push_back(s);
    endtask

    task automatic write_reg(input gbe_pkg::gbe_reg_t idx,
                             input logic [gbe_pkg::CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (imu_queue.size() != 0 || in_valid || pending_rates.size() != 0)
            @(posedge clk);
        // let a pending bias commit settle before touching registers
        repeat (8) @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (imu_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_sample = imu_queue.pop_front();
                in_valid <= 1'b1;
                time_ms  <= next_sample.stamp;
                gyro_x   <= next_sample.gx;
                gyro_y   <= next_sample.gy;
                gyro_z   <= next_sample.gz;
                accel_x  <= next_sample.ax;
                accel_y  <= next_sample.ay;
                accel_z  <= next_sample.az;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rates.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %0d %0d %0d %0b %0b",
                             $time, rate_x_corrected, rate_y_corrected, rate_z_corrected,
                             is_calibrated, was_stationary);
                    mismatches++;
                end
                else
                begin
                    want = pending_rates.pop_front();
                    check_field("rate_x_corrected", want.rate_x, rate_x_corrected);
                    check_field("rate_y_corrected", want.rate_y, rate_y_corrected);
                    check_field("rate_z_corrected", want.rate_z, rate_z_corrected);
                    check_field("is_calibrated", want.calibrated, is_calibrated);
                    check_field("was_stationary", want.stationary, was_stationary);
                end
            end
            if (in_valid && in_ready)
            begin
                seen_sample.stamp = time_ms;
                seen_sample.gx = gyro_x;
                seen_sample.gy = gyro_y;
                seen_sample.gz = gyro_z;
                seen_sample.ax = accel_x;
                seen_sample.ay = accel_y;
                seen_sample.az = accel_z;
                predict_rates(seen_sample, got);
                pending_rates.push_back(got);
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (gbe_pkg::gbe_reg_t'(cfg_index))
                    gbe_pkg::REG_CALIB_MS:  calib_ms_r  = cfg_data[gbe_pkg::TIME_WIDTH-1:0];
                    gbe_pkg::REG_GYRO_THR:  gyro_thr_r  = cfg_data[gbe_pkg::THR_WIDTH-1:0];
                    gbe_pkg::REG_ACCEL_TOL: accel_tol_r = cfg_data[gbe_pkg::THR_WIDTH-1:0];
                    gbe_pkg::REG_GRAVITY:   gravity_r   = cfg_data[gbe_pkg::THR_WIDTH-1:0];
                    gbe_pkg::REG_ALPHA:     alpha_r     = cfg_data[gbe_pkg::ALPHA_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
        in_taken <= in_valid && in_ready;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("gyro_bias_estimator verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        logic [gbe_pkg::CFG_DATA_WIDTH-1:0] calib_pick;
        logic [gbe_pkg::CFG_DATA_WIDTH-1:0] alpha_pick;
        int roll;
        for (phase = 0; phase < gbe_pkg::AXES; phase++)
        begin
            rate_sum[phase]  = '0;
            rate_bias[phase] = '0;
        end
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        time_ms   = '0;
        gyro_x    = '0;
        gyro_y    = '0;
        gyro_z    = '0;
        accel_x   = '0;
        accel_y   = '0;
        accel_z   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gbe_pkg::REG_CALIB_MS;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // startup window at reset settings; the 8000 ms sample closes it
        push_sample(0, 32767, 32767, 32767, -32768, -32768, -32768);
        push_sample(1, -32768, -32768, -32768, 32767, 32767, 32767);
        push_sample(5000, 37, -12, 5, 0, 0, 9807);
        push_sample(7999, -3, 40, -21, 1, 2, 3);
        push_sample(8000, 11, -7, 100, 0, 0, 9807);
        // calibrated: walk the gyro and accel bounds at reset thresholds
        push_sample(0, 5, -3, 2, 0, 0, 9807);
        push_sample(77, 79, 0, 0, 0, 0, 9807);
        push_sample(78, -80, 0, 0, 0, 0, 9807);
        push_sample(79, 0, 0, 0, 0, 10556, 0);
        push_sample(80, 0, 0, 0, 0, 10557, 0);
        push_sample(81, 0, 0, 0, -9058, 0, 0);
        push_sample(82, 0, 0, 0, -9057, 0, 0);
        push_sample(32'hFFFF_FFFF, 32767, -32768, 0, 0, 0, 0);
        wait_drained();

        // zero threshold: nothing passes
        write_reg(gbe_pkg::REG_GYRO_THR, 0);
        write_reg(gbe_pkg::REG_CALIB_MS, 0);
        push_sample(3, 1, 0, 0, 0, 0, 9807);
        wait_drained();

        // gravity equal to tolerance: zero accel fails, nonzero accel within the upper bound passes; full alpha
        write_reg(gbe_pkg::REG_GYRO_THR, LEVEL_MAX);
        write_reg(gbe_pkg::REG_GRAVITY, 500);
        write_reg(gbe_pkg::REG_ACCEL_TOL, 500);
        write_reg(gbe_pkg::REG_ALPHA, gbe_pkg::ALPHA_ONE);
        write_reg(gbe_pkg::REG_CALIB_MS, 32'hFFFF_FFFF);
        push_sample(4, 0, 0, 0, 0, 0, 0);
        push_sample(5, -1000, 20, 3, 0, 0, 1);
        wait_drained();

        // gravity below tolerance: no lower bound; alpha above one clamps
        write_reg(gbe_pkg::REG_GRAVITY, 0);
        write_reg(gbe_pkg::REG_ACCEL_TOL, LEVEL_MAX);
        write_reg(gbe_pkg::REG_ALPHA, ALPHA_MAX);
        push_sample(6, 10, -10, 10, 0, 0, 0);
        push_sample(7, 200, 100, -50, 32767, 32767, 32767);
        wait_drained();

        // alpha zero freezes the bias
        write_reg(gbe_pkg::REG_ALPHA, 0);
        push_sample(8, -7, 7, 0, 0, 0, 0);
        push_sample(9, -7, 7, 0, 0, 0, 0);
        wait_drained();

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            roll = $urandom_range(3);
            calib_pick = (roll == 0) ? 0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom();
            roll = $urandom_range(9);
            if (roll == 0)
                alpha_pick = 0;
            else if (roll == 1)
                alpha_pick = gbe_pkg::ALPHA_ONE;
            else if (roll == 2)
                alpha_pick = ALPHA_MAX;
            else if (roll < 8)
                alpha_pick = $urandom_range(4000, 1);
            else
                alpha_pick = $urandom_range(ALPHA_MAX, 0);
            write_reg(gbe_pkg::REG_CALIB_MS, calib_pick);
            write_reg(gbe_pkg::REG_GYRO_THR, pick_level(1, LEVEL_MAX, 20, 400));
            write_reg(gbe_pkg::REG_ACCEL_TOL, pick_level(1, LEVEL_MAX, 100, 2000));
            write_reg(gbe_pkg::REG_GRAVITY, pick_level(0, LEVEL_MAX, 4000, 16000));
            write_reg(gbe_pkg::REG_ALPHA, alpha_pick);
            idle_pct = (phase == CALM_PHASE) ? 0 : IDLE_PCT;
            repeat (PHASE_SAMPLES) imu_queue.push_back(make_sample());
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("gyro_bias_estimator verification clean");
        else
            $display("gyro_bias_estimator verification failed");
        $finish;
    end

endmodule
